@@ hw/rtl/mpaf_pkg.sv @@
// Package for the multi-pin activity finder.
// Holds the word types, field widths and shared constants; depends on nothing.
package mpaf_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_PINS_DEF   = 24;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field widths
  localparam int LEVEL_W  = 24;
  localparam int TX_W     = 5;
  localparam int IDX_W    = 8;
  localparam int EDGE_W   = 16;
  localparam int WORD_W   = 16;
  localparam int STATUS_W = 8;
  localparam int THR_W    = 16;

  // Codes and constants
  localparam logic [THR_W-1:0]    THRESHOLD_RESET = 16'd10;
  localparam logic [STATUS_W-1:0] FOUND_BIT       = 8'h80;
  localparam logic [IDX_W-1:0]    NO_PIN          = 8'hFF;
  localparam logic [IDX_W-1:0]    LOW_BYTE        = 8'hFF;

  // Input word: one parallel sample of all pins
  typedef struct packed {
    logic [LEVEL_W-1:0] pin_levels;
    logic               first_of_round;
    logic               last_of_round;
  } sample_t;

  // Result word of one evaluated round
  typedef struct packed {
    logic                found;
    logic [TX_W-1:0]     tx_index;
    logic [IDX_W-1:0]    best_rx_index;
    logic [EDGE_W-1:0]   best_edges;
    logic [WORD_W-1:0]   result_word;
    logic [STATUS_W-1:0] status_word;
  } result_t;

  // Per-sample control broadcast to every pin cell
  typedef struct packed {
    logic            take;
    logic            first;
    logic [TX_W-1:0] tx;
  } cell_ctrl_t;

  // Best-so-far marker that walks the cell chain during evaluation
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } wave_t;

endpackage

@@ hw/rtl/mpaf_pin_cell.sv @@
// One pin cell of the activity finder: reference level, saturating edge
// counter and one registered step of the busiest-pin search. Uses mpaf_pkg.
module mpaf_pin_cell #(
  parameter int COUNT_BITS = mpaf_pkg::COUNT_BITS_DEF,
  parameter int PIN        = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mpaf_pkg::cell_ctrl_t   ctrl,
  input  logic                   level,
  input  mpaf_pkg::wave_t        wave_in,
  input  logic [COUNT_BITS-1:0]  edges_in,
  output mpaf_pkg::wave_t        wave_out,
  output logic [COUNT_BITS-1:0]  edges_out
);
  import mpaf_pkg::*;

  localparam logic [TX_W-1:0]  PIN_TX  = TX_W'(PIN);
  localparam logic [IDX_W-1:0] PIN_IDX = IDX_W'(PIN);

  logic                  ref_level;
  logic [COUNT_BITS-1:0] count;
  logic                  is_rx;

  assign is_rx = (ctrl.tx != PIN_TX);

  // Latch the reference on a first sample, else count a level change on a receive pin
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_level <= 1'b0;
      count     <= '0;
    end else if (ctrl.take) begin
      if (ctrl.first) begin
        ref_level <= level;
        count     <= '0;
      end else if (is_rx && (level != ref_level)) begin
        ref_level <= level;
        if (count != {COUNT_BITS{1'b1}}) begin
          count <= count + 1'b1;
        end
      end
    end
  end

  // Advance the search marker one cell; strict compare keeps the lower pin on ties
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out.valid <= 1'b0;
    end else begin
      wave_out.valid <= wave_in.valid;
      if (wave_in.valid) begin
        if (is_rx && (count > edges_in)) begin
          wave_out.idx <= PIN_IDX;
          edges_out    <= count;
        end else begin
          wave_out.idx <= wave_in.idx;
          edges_out    <= edges_in;
        end
      end
    end
  end

endmodule

@@ hw/rtl/multi_pin_activity_finder.sv @@
// Multi-pin activity finder. Every clock a sample of all pins may be taken;
// a row of pin cells counts level changes on every pin but the transmit pin.
// A last-of-round sample starts a search that walks the cell row one pin per
// clock, so its result word passes through the cell registers, the catch
// register and the output register, and sample_stall stays high from the
// clock after that sample is taken until the result is loaded into the output
// register. Other samples go through one per clock. Once a pair is found, later
// samples are taken and ignored. Uses mpaf_pkg and mpaf_pin_cell.
module multi_pin_activity_finder #(
  parameter int NUM_PINS   = mpaf_pkg::NUM_PINS_DEF,
  parameter int COUNT_BITS = mpaf_pkg::COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sample_valid,
  output logic                     sample_stall,
  input  mpaf_pkg::sample_t        sample,
  output logic                     result_valid,
  input  logic                     result_stall,
  output mpaf_pkg::result_t        result,
  input  logic                     threshold_we,
  input  logic [mpaf_pkg::THR_W-1:0] threshold_wdata
);
  import mpaf_pkg::*;

  localparam logic [TX_W-1:0] LAST_TX = TX_W'(NUM_PINS - 1);

  logic [THR_W-1:0]      edge_threshold;
  logic [TX_W-1:0]       transmit_index;
  logic                  pair_found;
  logic [WORD_W-1:0]     best_word;
  logic                  busy;
  logic                  start;
  logic                  fin_valid;
  logic [IDX_W-1:0]      fin_idx;
  logic [COUNT_BITS-1:0] fin_edges;

  logic                  accept;
  logic                  commit;
  cell_ctrl_t            ctrl;
  wave_t                 wave     [NUM_PINS+1];
  logic [COUNT_BITS-1:0] edges    [NUM_PINS+1];

  logic [THR_W-1:0]      thr_eff;
  logic [EDGE_W-1:0]     fin_edges_w;
  logic                  hit;
  logic [IDX_W-1:0]      low_count;
  logic [TX_W-1:0]       tx_next;
  logic [WORD_W-1:0]     best_word_next;
  logic                  found_next;

  assign sample_stall = busy;
  assign accept       = sample_valid && !sample_stall;

  assign ctrl.take  = accept && !pair_found;
  assign ctrl.first = sample.first_of_round;
  assign ctrl.tx    = transmit_index;

  // Hold the threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_threshold <= THRESHOLD_RESET;
    end else if (threshold_we) begin
      edge_threshold <= threshold_wdata;
    end
  end

  // Seed the search marker with no pin and a zero count
  assign wave[0].valid = start;
  assign wave[0].idx   = NO_PIN;
  assign edges[0]      = '0;

  // Row of pin cells
  for (genvar p = 0; p < NUM_PINS; p++) begin : g_pin
    logic level;
    if (p < LEVEL_W) begin : g_lvl
      assign level = sample.pin_levels[p];
    end else begin : g_zero
      assign level = 1'b0;
    end

    mpaf_pin_cell #(
      .COUNT_BITS (COUNT_BITS),
      .PIN        (p)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .level     (level),
      .wave_in   (wave[p]),
      .edges_in  (edges[p]),
      .wave_out  (wave[p+1]),
      .edges_out (edges[p+1])
    );
  end

  // Start the search the clock after a last sample, hold input until commit
  always_ff @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      busy  <= 1'b0;
    end else begin
      start <= ctrl.take && sample.last_of_round;
      if (ctrl.take && sample.last_of_round) begin
        busy <= 1'b1;
      end else if (commit) begin
        busy <= 1'b0;
      end
    end
  end

  // Catch the search outcome at the end of the row
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (wave[NUM_PINS].valid) begin
      fin_valid <= 1'b1;
    end else if (commit) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wave[NUM_PINS].valid) begin
      fin_idx   <= wave[NUM_PINS].idx;
      fin_edges <= edges[NUM_PINS];
    end
  end

  assign commit = fin_valid && (!result_valid || !result_stall);

  // Decide the round: found, or keep the best low count and move on
  always_comb begin
    thr_eff        = (edge_threshold == '0) ? THR_W'(1) : edge_threshold;
    fin_edges_w    = EDGE_W'(fin_edges);
    hit            = (fin_edges_w >= thr_eff);
    low_count      = (fin_edges_w > EDGE_W'(LOW_BYTE)) ? LOW_BYTE : fin_edges[IDX_W-1:0];
    found_next     = pair_found;
    tx_next        = transmit_index;
    best_word_next = best_word;
    if (hit) begin
      found_next     = 1'b1;
      best_word_next = {IDX_W'(transmit_index), fin_idx};
    end else begin
      if (low_count > best_word[IDX_W-1:0]) begin
        best_word_next = {IDX_W'(transmit_index), low_count};
      end
      tx_next = (transmit_index == LAST_TX) ? '0 : transmit_index + 1'b1;
    end
  end

  // Update round state at commit
  always_ff @(posedge clk) begin
    if (rst) begin
      transmit_index <= '0;
      pair_found     <= 1'b0;
      best_word      <= '0;
    end else if (commit) begin
      transmit_index <= tx_next;
      pair_found     <= found_next;
      best_word      <= best_word_next;
    end
  end

  // Output register: load at commit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result.found         <= found_next;
      result.tx_index      <= tx_next;
      result.best_rx_index <= fin_idx;
      result.best_edges    <= fin_edges_w;
      result.result_word   <= best_word_next;
      result.status_word   <= STATUS_W'(tx_next) | (found_next ? FOUND_BIT : '0);
    end
  end

`ifndef NO_ASSERTIONS
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall && sample.last_of_round && !pair_found) |=> sample_stall)
    else $error("input not held off after a last sample");

  a_fin_holds_input: assert property (@(posedge clk) disable iff (rst)
    fin_valid |-> sample_stall)
    else $error("sample taken while a round result is pending");

  a_found_sticks: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !$fell(pair_found))
    else $error("found flag cleared outside reset");

  a_tx_in_range: assert property (@(posedge clk) disable iff (rst)
    transmit_index <= LAST_TX)
    else $error("transmit index past last pin");

  a_found_has_pin: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.found) |-> (result.best_rx_index != NO_PIN))
    else $error("found result without a receive pin");
`endif

endmodule
